@@ rtl/lz_escape_code_decompressor_defines.svh @@
// Assertion macros for the decompressor RTL.
// Define SYNTH to compile the checks out.
`ifndef LZ_ESCAPE_CODE_DECOMPRESSOR_DEFINES_SVH
`define LZ_ESCAPE_CODE_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check.
`define LZD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzd assertion failed");
// Next-cycle implication check.
`define LZD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzd assertion failed");
`else
`define LZD_ASSERT_IMP(name, clk, rst, ante, cons)
`define LZD_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

@@ rtl/lzd_pkg.sv @@
`timescale 1ns / 1ps
package lzd_pkg;

   // History RAM geometry
   localparam int HIST_AW = 16;
   localparam int HIST_ENTRIES = 1 << HIST_AW;
   localparam logic [32:0] HIST_LIMIT = 33'(HIST_ENTRIES);

   // Stream format
   localparam int HDR_BYTES = 9;
   localparam int LEN_FIRST = 4;
   localparam int COUNT_SHIFT = 3;
   localparam int COUNT_HI_SHIFT = 5;
   localparam int COUNT_BIAS = 4;

   // Parser phases
   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_TOKEN   = 3'd1;
   localparam logic [2:0] PH_CONTROL = 3'd2;
   localparam logic [2:0] PH_COUNTHI = 3'd3;
   localparam logic [2:0] PH_DIST    = 3'd4;
   localparam logic [2:0] PH_COPY    = 3'd5;
   localparam logic [2:0] PH_DONE    = 3'd6;

   // Item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_COPY = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_DIST   = 2'd1;
   localparam logic [1:0] ERR_AFTER_DONE = 2'd2;

   // Queue between parser and history engine
   localparam int QUEUE_AW = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic       stream_start;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       copy_pending;
      logic       done_res;
      logic [1:0] error;
   } rsp_type;

   // One classified transaction headed for the history engine
   typedef struct packed {
      logic               has_byte;
      logic               is_copy;
      logic [7:0]         lit_byte;
      logic [HIST_AW-1:0] wr_addr;
      logic [HIST_AW-1:0] rd_addr;
      logic               copy_pending;
      logic               done_res;
      logic [1:0]         error;
   } op_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

@@ rtl/lzd_front.sv @@
`timescale 1ns / 1ps
module lzd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  lzd_pkg::req_type req,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data,
   output lzd_pkg::op_type  op
);
   import lzd_pkg::*;

   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         hdr_idx_ff, hdr_idx_in;
   logic [7:0]         esc_ff, esc_in;
   logic [31:0]        plen_ff, plen_in;
   logic [31:0]        pcons_ff, pcons_in;
   logic [31:0]        bprod_ff, bprod_in;
   logic [1:0]         tctl_ff, tctl_in;
   logic [13:0]        mcount_ff, mcount_in;
   logic [31:0]        mdist_ff, mdist_in;
   logic [2:0]         didx_ff, didx_in;
   logic [HIST_AW-1:0] hwp_ff, hwp_in;
   logic [31:0]        olen_ff;

   // state as seen by this transaction (stream start clears it first)
   logic [2:0]         phase_c;
   logic [3:0]         hdr_idx_c;
   logic [7:0]         esc_c;
   logic [31:0]        plen_c, pcons_c, bprod_c, mdist_c;
   logic [1:0]         tctl_c;
   logic [13:0]        mcount_c, mcount_dec;
   logic [2:0]         didx_c;
   logic [HIST_AW-1:0] hwp_c, hwp_inc;
   logic               kind_c;
   logic [7:0]         b, bb;
   logic [31:0]        pcons_inc, bprod_inc, raw_n;

   // end-of-stream check made between tokens
   function automatic logic [2:0] after_token(input logic [31:0] pc, input logic [31:0] pl,
                                              input logic [31:0] bp, input logic [31:0] ol);
      return (pc >= pl || bp >= ol) ? PH_DONE : PH_TOKEN;
   endfunction

   always_comb begin
      if (req.stream_start) begin
         phase_c   = PH_HEADER;
         hdr_idx_c = '0;
         esc_c     = '0;
         plen_c    = '0;
         pcons_c   = '0;
         bprod_c   = '0;
         tctl_c    = '0;
         mcount_c  = '0;
         mdist_c   = '0;
         didx_c    = '0;
         hwp_c     = '0;
      end else begin
         phase_c   = phase_ff;
         hdr_idx_c = hdr_idx_ff;
         esc_c     = esc_ff;
         plen_c    = plen_ff;
         pcons_c   = pcons_ff;
         bprod_c   = bprod_ff;
         tctl_c    = tctl_ff;
         mcount_c  = mcount_ff;
         mdist_c   = mdist_ff;
         didx_c    = didx_ff;
         hwp_c     = hwp_ff;
      end
      kind_c     = req.stream_start ? KIND_BYTE : req.kind;
      b          = req.data_byte;
      bb         = (b > esc_c) ? b - 8'd1 : b;
      pcons_inc  = (pcons_c == '1) ? pcons_c : pcons_c + 32'd1;
      bprod_inc  = bprod_c + 32'd1;
      hwp_inc    = hwp_c + 1'b1;
      mcount_dec = mcount_c - 14'd1;
      raw_n      = mdist_c | (32'(b) << {didx_c[1:0], 3'b000});

      phase_in   = phase_c;
      hdr_idx_in = hdr_idx_c;
      esc_in     = esc_c;
      plen_in    = plen_c;
      pcons_in   = pcons_c;
      bprod_in   = bprod_c;
      tctl_in    = tctl_c;
      mcount_in  = mcount_c;
      mdist_in   = mdist_c;
      didx_in    = didx_c;
      hwp_in     = hwp_c;

      op          = '0;
      op.wr_addr  = hwp_c;
      op.rd_addr  = hwp_c + ~mdist_c[HIST_AW-1:0];
      op.error    = ERR_NONE;

      if (phase_c == PH_DONE) begin
         op.error = ERR_AFTER_DONE;
      end else if (kind_c == KIND_COPY) begin
         // one match byte per copy request
         if (phase_c == PH_COPY) begin
            op.has_byte = 1'b1;
            op.is_copy  = 1'b1;
            hwp_in      = hwp_inc;
            bprod_in    = bprod_inc;
            mcount_in   = mcount_dec;
            if (bprod_inc >= olen_ff) begin
               mcount_in = '0;
               phase_in  = PH_DONE;
            end else if (mcount_dec == '0) begin
               phase_in = after_token(pcons_c, plen_c, bprod_inc, olen_ff);
            end
         end
      end else begin
         unique case (phase_c)
            PH_HEADER: begin
               if (hdr_idx_c >= 4'(LEN_FIRST) && hdr_idx_c < 4'(LEN_FIRST + 4)) begin
                  plen_in = plen_c | (32'(b) << {hdr_idx_c[1:0], 3'b000});
               end
               if (hdr_idx_c == 4'(HDR_BYTES - 1)) begin
                  esc_in   = b;
                  phase_in = after_token(pcons_c, plen_c, bprod_c, olen_ff);
               end else begin
                  hdr_idx_in = hdr_idx_c + 4'd1;
               end
            end
            PH_TOKEN: begin
               pcons_in = pcons_inc;
               if (b != esc_c) begin
                  op.has_byte = 1'b1;
                  op.lit_byte = b;
                  hwp_in      = hwp_inc;
                  bprod_in    = bprod_inc;
                  phase_in    = after_token(pcons_inc, plen_c, bprod_inc, olen_ff);
               end else begin
                  phase_in = PH_CONTROL;
               end
            end
            PH_CONTROL: begin
               pcons_in = pcons_inc;
               if (b == esc_c) begin
                  // escaped literal
                  op.has_byte = 1'b1;
                  op.lit_byte = b;
                  hwp_in      = hwp_inc;
                  bprod_in    = bprod_inc;
                  phase_in    = after_token(pcons_inc, plen_c, bprod_inc, olen_ff);
               end else begin
                  tctl_in   = bb[1:0];
                  mcount_in = 14'(bb >> COUNT_SHIFT);
                  mdist_in  = '0;
                  didx_in   = '0;
                  phase_in  = bb[2] ? PH_COUNTHI : PH_DIST;
               end
            end
            PH_COUNTHI: begin
               pcons_in  = pcons_inc;
               mcount_in = mcount_c | (14'(b) << COUNT_HI_SHIFT);
               phase_in  = PH_DIST;
            end
            PH_DIST: begin
               pcons_in = pcons_inc;
               mdist_in = raw_n;
               didx_in  = didx_c + 3'd1;
               if (didx_c + 3'd1 >= 3'(tctl_c) + 3'd1) begin
                  mcount_in = mcount_c + 14'(COUNT_BIAS);
                  // stored distance is one less than the true distance
                  if (raw_n >= bprod_c || {1'b0, raw_n} >= HIST_LIMIT) begin
                     op.error  = ERR_BAD_DIST;
                     mcount_in = '0;
                     phase_in  = after_token(pcons_inc, plen_c, bprod_c, olen_ff);
                  end else begin
                     phase_in = PH_COPY;
                  end
               end
            end
            default: begin
               // copy pending: compressed byte is ignored
            end
         endcase
      end

      op.copy_pending = (phase_in == PH_COPY);
      op.done_res     = (phase_in == PH_DONE);
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= '0;
         esc_ff     <= '0;
         plen_ff    <= '0;
         pcons_ff   <= '0;
         bprod_ff   <= '0;
         tctl_ff    <= '0;
         mcount_ff  <= '0;
         mdist_ff   <= '0;
         didx_ff    <= '0;
         hwp_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         esc_ff     <= esc_in;
         plen_ff    <= plen_in;
         pcons_ff   <= pcons_in;
         bprod_ff   <= bprod_in;
         tctl_ff    <= tctl_in;
         mcount_ff  <= mcount_in;
         mdist_ff   <= mdist_in;
         didx_ff    <= didx_in;
         hwp_ff     <= hwp_in;
      end
   end

   // output length register
   always_ff @(posedge clock) begin
      if (reset) begin
         olen_ff <= '0;
      end else if (csr_write_enable) begin
         olen_ff <= csr_write_data;
      end
   end

endmodule

@@ rtl/lzd_queue.sv @@
`timescale 1ns / 1ps
module lzd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lzd_pkg::op_type       push_op,
   input  logic                  pop,
   output lzd_pkg::op_type       pop_op,
   output lzd_pkg::q_status_type status
);
   import lzd_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign pop_op           = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ rtl/lzd_back.sv @@
`timescale 1ns / 1ps
module lzd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lzd_pkg::op_type       q_op,
   input  lzd_pkg::q_status_type q_stat,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lzd_pkg::rsp_type      rsp_data
);
   import lzd_pkg::*;

   logic [7:0]  hist_mem [HIST_ENTRIES];
   logic [7:0]  rd_data_ff;
   logic        byp_ff;
   logic [7:0]  byp_data_ff;
   logic        s1_valid_ff;
   op_type      s1_op_ff;
   logic        s1_adv;
   logic [7:0]  s1_byte;
   logic        hist_we;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   // stage 1 moves on when the output register is free or being taken
   assign s1_adv  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = q_stat.not_empty && (!s1_valid_ff || s1_adv);
   assign hist_we = s1_adv && s1_op_ff.has_byte;

   // copy byte comes from the RAM, or from the write that collided with the read
   assign s1_byte = s1_op_ff.is_copy ? (byp_ff ? byp_data_ff : rd_data_ff) : s1_op_ff.lit_byte;

   // history RAM: one write, one registered read
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[s1_op_ff.wr_addr] <= s1_byte;
      end
      if (q_pop) begin
         rd_data_ff <= hist_mem[q_op.rd_addr];
      end
   end

   // read-during-write bypass and stage 1 payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         byp_ff      <= hist_we && (s1_op_ff.wr_addr == q_op.rd_addr);
         byp_data_ff <= s1_byte;
         s1_op_ff    <= q_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (q_pop) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff.out_valid    <= s1_op_ff.has_byte;
         rsp_ff.out_byte     <= s1_op_ff.has_byte ? s1_byte : 8'd0;
         rsp_ff.copy_pending <= s1_op_ff.copy_pending;
         rsp_ff.done_res     <= s1_op_ff.done_res;
         rsp_ff.error        <= s1_op_ff.error;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/lz_escape_code_decompressor.sv @@
// An accepted transaction is queued, goes to stage 1 with its RAM read, then to the output
// register. Throughput: one transaction per cycle, literal or copy, unless stalled; history
// RAM gives one read and one write per cycle, bypassing reads of the byte being written.
// Reset: synchronous, active high; clears parser, queue, pipeline valids and output length.
// The 64 KiB history RAM is not cleared; a stream only reads bytes it has written.
`timescale 1ns / 1ps
`include "lz_escape_code_decompressor_defines.svh"
module lz_escape_code_decompressor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lzd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lzd_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data
);
   import lzd_pkg::*;

   logic         req_accept;
   op_type       front_op;
   op_type       q_op;
   q_status_type q_stat;
   logic         q_pop;

   assign req_stall  = q_stat.full;
   assign req_accept = req_valid && !req_stall;

   // parser and classifier
   lzd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .req              (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .op               (front_op)
   );

   // transaction queue
   lzd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept),
      .push_op (front_op),
      .pop     (q_pop),
      .pop_op  (q_op),
      .status  (q_stat)
   );

   // history engine and output register
   lzd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_op      (q_op),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // checks
   `LZD_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, q_stat.not_empty)
   `LZD_ASSERT_NXT(a_accept_queued, clock, reset, req_accept, q_stat.not_empty)
   `LZD_ASSERT_IMP(a_err_done, clock, reset, rsp_valid && rsp_data.error == ERR_AFTER_DONE, rsp_data.done_res)
   `LZD_ASSERT_IMP(a_no_byte_zero, clock, reset, rsp_valid && !rsp_data.out_valid, rsp_data.out_byte == 8'd0)

endmodule
